### sv/sus_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted unique set table.
// No dependencies; imported by sus_cell, the top level and the testbench.
package sus_pkg;

  localparam int unsigned VAL_W        = 16;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned SIZE_CEILING = 65535;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TRUNC  = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_NOCHG = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  typedef struct packed {
    op_t              op;
    logic [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
    logic [CNT_W-1:0] count;
    stat_t            status;
  } out_t;

  // Controls broadcast to every cell of the chain
  typedef struct packed {
    logic             cmp_en;
    logic [VAL_W-1:0] cmp_value;
    logic             ins;
    logic             rem;
    logic [VAL_W-1:0] ins_value;
  } cell_ctl_t;

endpackage

### sv/sus_cell.sv
`timescale 1ns / 1ps
// One table cell: holds an entry, compares it against the probe value and
// shifts with its neighbors on insert/remove. Depends on sus_pkg.
module sus_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  logic                     clk,
  input  sus_pkg::cell_ctl_t       ctl,
  input  logic [CW-1:0]            count,
  input  logic                     left_lt,
  input  logic [sus_pkg::VAL_W-1:0] left_entry,
  input  logic [sus_pkg::VAL_W-1:0] right_entry,
  output logic [sus_pkg::VAL_W-1:0] entry_r,
  output logic                     lt_r,
  output logic                     eq_r
);
  import sus_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic             valid;
  logic [VAL_W-1:0] entry_nxt;

  assign valid = (IDX_C < count);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins && !lt_r) begin
      // boundary cell takes the new value, cells above shift up
      entry_nxt = left_lt ? ctl.ins_value : left_entry;
    end else if (ctl.rem && !lt_r) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.cmp_en) begin
      lt_r <= valid && (entry_r < ctl.cmp_value);
      eq_r <= valid && (entry_r == ctl.cmp_value);
    end
  end

endmodule

### sv/sus_pos_enc.sv
`timescale 1ns / 1ps
// One-hot to binary encoder for the lower-bound position of the cell chain.
// Self-contained; used by the top level.
module sus_pos_enc #(
  parameter int unsigned N  = 64,
  parameter int unsigned PW = 7
) (
  input  logic [N:0]    onehot,
  output logic [PW-1:0] idx
);

  always_comb begin
    idx = '0;
    for (int i = 0; i <= N; i++) begin
      if (onehot[i]) begin
        idx = idx | PW'(i);
      end
    end
  end

endmodule

### sv/sorted_unique_set_table.sv
`timescale 1ns / 1ps
// Sorted unique set table: an ascending table of distinct 16-bit values
// held in a chain of cells. Depends on sus_pkg, sus_cell and sus_pos_enc.
//
// Usage:
//   in_valid/in_ready/in_data carry one operation (insert, remove,
//   truncate at or above, find) and a value. Every transaction yields
//   exactly one result on out_valid/out_ready/out_data with the
//   lower-bound position, a found flag, the new count and a status.
//   Each item has a compare step, in which all cells compare their entry
//   against the value in parallel (on the accepting edge), and an update
//   step, in which the position is encoded and the cells shift in parallel.
//   The result is registered; out_valid rises at the edge that completes
//   the update step, and in_ready comes back at that same edge.
//   A new item is not accepted before the last one's update is done; the
//   table update of one item must finish before the next compare reads it.
//   If the receiver stalls, the finished result waits in the output
//   register; a next item is still accepted and compared, and its update
//   waits until the output register is taken.
//   Reset empties the table (count 0); entries need no clearing since
//   only cells below the count are ever compared.
module sorted_unique_set_table #(
  parameter int unsigned CAPACITY = sus_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sus_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sus_pkg::out_t out_data
);
  import sus_pkg::*;

  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned LIMIT = (CAPACITY < SIZE_CEILING) ? CAPACITY : SIZE_CEILING;

  typedef enum logic [1:0] {
    S_CMP = 2'b01,
    S_UPD = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  op_t              op_r;
  logic [VAL_W-1:0] value_r;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  cell_ctl_t        ctl;
  logic [VAL_W-1:0] entry_q [CAPACITY];
  logic [CAPACITY-1:0] lt_vec, eq_vec;
  logic [CAPACITY:0]   bound;
  logic [CW-1:0]    pos;
  logic             hit;
  logic             in_fire, upd_fire;
  logic             do_ins, do_rem;
  stat_t            status;

  assign in_ready  = state_r[0];
  assign in_fire   = in_valid && in_ready;
  assign upd_fire  = state_r[1] && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Cell chain
  assign ctl.cmp_en    = in_fire;
  assign ctl.cmp_value = in_data.value;
  assign ctl.ins       = do_ins;
  assign ctl.rem       = do_rem;
  assign ctl.ins_value = value_r;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic             l_lt;
    logic [VAL_W-1:0] l_entry, r_entry;
    if (g == 0) begin : g_first
      assign l_lt    = 1'b1;
      assign l_entry = '0;
    end else begin : g_mid
      assign l_lt    = lt_vec[g-1];
      assign l_entry = entry_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign r_entry = entry_q[g];
    end else begin : g_inner
      assign r_entry = entry_q[g+1];
    end
    sus_cell #(.IDX(g), .CW(CW)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .left_lt    (l_lt),
      .left_entry (l_entry),
      .right_entry(r_entry),
      .entry_r    (entry_q[g]),
      .lt_r       (lt_vec[g]),
      .eq_r       (eq_vec[g])
    );
  end

  // lt flags form a thermometer; the edge marks the lower bound
  assign bound[0]        = !lt_vec[0];
  assign bound[CAPACITY] = lt_vec[CAPACITY-1];
  for (genvar b = 1; b < CAPACITY; b++) begin : g_bound
    assign bound[b] = lt_vec[b-1] && !lt_vec[b];
  end

  sus_pos_enc #(.N(CAPACITY), .PW(CW)) u_enc (
    .onehot(bound),
    .idx   (pos)
  );

  assign hit = |eq_vec;

  always_comb begin
    do_ins    = 1'b0;
    do_rem    = 1'b0;
    status    = STAT_OK;
    count_nxt = count_r;
    unique case (op_r)
      OP_INSERT: begin
        if (hit) begin
          status = STAT_NOCHG;
        end else if (count_r >= CW'(LIMIT)) begin
          status = STAT_FULL;
        end else begin
          do_ins    = upd_fire;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (!hit) begin
          status = STAT_NOCHG;
        end else begin
          do_rem    = upd_fire;
          count_nxt = count_r - CW'(1);
        end
      end
      OP_TRUNC: begin
        if (pos >= count_r) begin
          status = STAT_NOCHG;
        end else begin
          count_nxt = pos;
        end
      end
      OP_FIND: begin
        status = STAT_OK;
      end
      default: begin
        status = STAT_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CMP: begin
        if (in_fire) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (upd_fire) begin
          state_nxt             = S_CMP;
          out_valid_nxt         = 1'b1;
          out_data_nxt.position = POS_W'(pos);
          out_data_nxt.found    = hit;
          out_data_nxt.count    = CNT_W'(count_nxt);
          out_data_nxt.status   = status;
        end
      end
      default: begin
        state_nxt = S_CMP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CMP;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (upd_fire) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      op_r    <= in_data.op;
      value_r <= in_data.value;
    end
  end

endmodule

### tb/sus_table_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted unique set table: keeps its own table, predicts the
// result of each input transaction and compares it. Depends on sus_pkg.
module sus_table_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  sus_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  sus_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);
  import sus_pkg::*;

  localparam int unsigned TABLE_LIMIT =
    (CAPACITY_DEF < SIZE_CEILING) ? CAPACITY_DEF : SIZE_CEILING;

  logic [VAL_W-1:0] set_vals [TABLE_LIMIT];
  int unsigned      set_size;
  out_t             expected_results [$];

  // Apply one operation to the local table and return its result.
  function automatic out_t apply_set_op(input op_t op, input logic [VAL_W-1:0] v);
    out_t        res;
    int unsigned lb;
    logic        hit;
    stat_t       st;
    lb  = 0;
    st  = STAT_OK;
    while (lb < set_size && set_vals[lb] < v) lb++;
    hit = (lb < set_size) && (set_vals[lb] == v);
    case (op)
      OP_INSERT: begin
        if (hit) begin
          st = STAT_NOCHG;
        end else if (set_size >= TABLE_LIMIT) begin
          st = STAT_FULL;
        end else begin
          for (int i = set_size; i > lb; i--) set_vals[i] = set_vals[i-1];
          set_vals[lb] = v;
          set_size++;
        end
      end
      OP_REMOVE: begin
        if (!hit) begin
          st = STAT_NOCHG;
        end else begin
          for (int i = lb; i + 1 < set_size; i++) set_vals[i] = set_vals[i+1];
          set_size--;
        end
      end
      OP_TRUNC: begin
        if (lb >= set_size) st = STAT_NOCHG;
        else set_size = lb;
      end
      default: ;
    endcase
    res.position = lb[POS_W-1:0];
    res.found    = hit;
    res.count    = set_size[CNT_W-1:0];
    res.status   = st;
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    set_size   = 0;
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      set_size = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing pending: %p", out_data);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.position !== want.position) begin
            $error("position mismatch: expected %0d, got %0d",
                   want.position, out_data.position);
            fail_count++;
          end
          if (out_data.found !== want.found) begin
            $error("found mismatch: expected %0d, got %0d", want.found, out_data.found);
            fail_count++;
          end
          if (out_data.count !== want.count) begin
            $error("count mismatch: expected %0d, got %0d", want.count, out_data.count);
            fail_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d",
                   want.status, out_data.status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_set_op(in_data.op, in_data.value));
    end
    pending = expected_results.size();
  end

endmodule

### tb/sorted_unique_set_table_tb.sv
`timescale 1ns / 1ps
// Testbench top for the sorted unique set table: clock, reset, stimulus and
// verdict. Depends on sus_pkg, sorted_unique_set_table and sus_table_checker.
module sorted_unique_set_table_tb;
  import sus_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  bit   steady = 1'b0;

  always #2 clk = ~clk;

  sorted_unique_set_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sus_table_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver stalls about 12% of cycles, except during the steady stretch
  always @(negedge clk) begin
    if (rst_n) out_ready <= steady || ($urandom_range(99) >= 12);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  // in_valid is only lowered on a gap, so back-to-back items keep it high.
  task automatic send_item(input op_t op, input logic [VAL_W-1:0] v);
    while (!steady && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data.op    <= op;
    in_data.value <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Fixed pool so that hits on present values are frequent
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned k;
    if ($urandom_range(1) == 0) return VAL_W'($urandom_range(16'hFFFF));
    k = $urandom_range(POOL_SIZE - 1);
    return (k == POOL_SIZE - 1) ? 16'hFFFF : VAL_W'(k * 829);
  endfunction

  // Weighted op choice: thresholds on a 0..99 draw
  function automatic op_t pick_op(input int ins_w, input int rem_w, input int trunc_w);
    int unsigned r;
    r = $urandom_range(99);
    if (r < ins_w) return OP_INSERT;
    if (r < ins_w + rem_w) return OP_REMOVE;
    if (r < ins_w + rem_w + trunc_w) return OP_TRUNC;
    return OP_FIND;
  endfunction

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table, extremes, duplicates, absent removes, truncations
    send_item(OP_FIND,   16'h0000);
    send_item(OP_REMOVE, 16'h0005);
    send_item(OP_TRUNC,  16'h0000);
    send_item(OP_INSERT, 16'h8000);
    send_item(OP_INSERT, 16'h0000);
    send_item(OP_INSERT, 16'hFFFF);
    send_item(OP_INSERT, 16'h0000);
    send_item(OP_FIND,   16'hFFFF);
    send_item(OP_FIND,   16'h7FFF);
    send_item(OP_FIND,   16'h8001);
    send_item(OP_REMOVE, 16'h1234);
    send_item(OP_REMOVE, 16'h0000);
    send_item(OP_INSERT, 16'h5555);
    send_item(OP_INSERT, 16'hAAAA);
    send_item(OP_TRUNC,  16'hFFFF);
    send_item(OP_TRUNC,  16'hFFFF);
    send_item(OP_TRUNC,  16'h9000);
    send_item(OP_INSERT, 16'h0001);
    send_item(OP_TRUNC,  16'h0000);
    send_item(OP_FIND,   16'h0000);

    // Fill phase: mostly inserts, drives the table to full and keeps it there
    for (int i = 0; i < 100; i++)
      send_item(pick_op(85, 5, 0), pick_value());

    // Mixed phase, with a stretch of no idling on either side
    for (int i = 0; i < 230; i++) begin
      steady = (i >= 60 && i < 160);
      if (i == 200) begin
        // refill before the tail so full-table cases show up again
        for (int j = 0; j < 50; j++) send_item(OP_INSERT, pick_value());
      end
      send_item(pick_op(40, 30, 8), pick_value());
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
